[design/arb_pkg.sv]
// Shared constants, codes and types of the arcball rotation unit.
// No dependencies; arb_if, arb_front, arb_back, the top level and the testbench use it.
package arb_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int POINT_BITS_DEF = 13;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 14;
	localparam int OUT_W          = 18;
	localparam int MUL_W          = 32;
	localparam int SQ_W           = 64;
	localparam int ROOT_W         = SQ_W / 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_MODE   = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_CLICK = 1'b0,
		KIND_DRAG  = 1'b1
	} kind_t;

	typedef enum logic {
		MODE_LOOKAT = 1'b0,
		MODE_ORBIT  = 1'b1
	} mode_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] width;
		logic [CFG_DATA_W-1:0] height;
		mode_t                 mode;
	} cfg_t;

endpackage

[design/arb_if.sv]
// Channel interfaces of the arcball rotation unit: pointer items, results
// and configuration writes. Depends on arb_pkg.
interface arb_point_if #(
	parameter int POINT_BITS = arb_pkg::POINT_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [POINT_BITS-1:0] point_x;
	logic [POINT_BITS-1:0] point_y;

	modport source (output valid, kind, point_x, point_y, input ready);
	modport sink (input valid, kind, point_x, point_y, output ready);
endinterface

interface arb_result_if ();
	logic                               valid;
	logic                               ready;
	logic signed [arb_pkg::OUT_W-1:0]   rot_w;
	logic signed [arb_pkg::OUT_W-1:0]   rot_x;
	logic signed [arb_pkg::OUT_W-1:0]   rot_y;
	logic signed [arb_pkg::OUT_W-1:0]   rot_z;
	logic                               changed;

	modport source (output valid, rot_w, rot_x, rot_y, rot_z, changed, input ready);
	modport sink (input valid, rot_w, rot_x, rot_y, rot_z, changed, output ready);
endinterface

interface arb_cfg_if ();
	logic                              valid;
	logic                              ready;
	logic [arb_pkg::CFG_IDX_W-1:0]     index;
	logic [arb_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[design/arb_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by arb_back for scaling and normalization.
module arb_div #(
	parameter int NW = 46,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          fits;

	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		fits  = trial >= {1'b0, den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= num;
				cnt_q  <= CW'(NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= fits ? DW'(trial - {1'b0, den}) : DW'(trial);
				quo_q  <= {quo_q[NW-2:0], fits};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
endmodule

[design/arb_sqrt.sv]
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on nothing; used by arb_back for sphere z and vector lengths.
module arb_sqrt #(
	parameter int W = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   din,
	output logic           busy,
	output logic           done,
	output logic [W/2-1:0] root
);
	logic [W-1:0] v_q;
	logic [W-1:0] r_q;
	logic [W-1:0] b_q;
	logic         busy_q;
	logic         done_q;
	logic [W-1:0] rb;

	assign rb = r_q + b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				v_q    <= din;
				r_q    <= '0;
				b_q    <= W'(1) << (W - 2);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (v_q >= rb) begin
					v_q <= v_q - rb;
					r_q <= (r_q >> 1) + b_q;
				end else begin
					r_q <= r_q >> 1;
				end
				b_q <= b_q >> 2;
				if (b_q == W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = r_q[W/2-1:0];
endmodule

[design/arb_front.sv]
// Front end: configuration registers and a two-entry queue of pointer items.
// Depends on arb_pkg and the channel interfaces in arb_if.
module arb_front #(
	parameter int POINT_BITS = arb_pkg::POINT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	arb_point_if.sink             pointer,
	arb_cfg_if.sink               cfg,
	output arb_pkg::cfg_t         cfg_regs,
	output logic                  q_valid,
	input  logic                  q_pop,
	output arb_pkg::kind_t        q_kind,
	output logic [POINT_BITS-1:0] q_px,
	output logic [POINT_BITS-1:0] q_py
);
	import arb_pkg::*;

	cfg_t                  cfg_q;
	kind_t                 kind_e [2];
	logic [POINT_BITS-1:0] px_e [2];
	logic [POINT_BITS-1:0] py_e [2];
	logic                  wr_q;
	logic                  rd_q;
	logic [1:0]            cnt_q;
	logic                  push;

	assign pointer.ready = cnt_q != 2'd2;
	assign cfg.ready     = 1'b1;
	assign push          = pointer.valid && pointer.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= CFG_DATA_W'(640);
			cfg_q.height <= CFG_DATA_W'(480);
			cfg_q.mode   <= MODE_LOOKAT;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_WIDTH: begin
					cfg_q.width <= cfg.data;
				end
				REG_HEIGHT: begin
					cfg_q.height <= cfg.data;
				end
				REG_MODE: begin
					cfg_q.mode <= mode_t'(cfg.data[0]);
				end
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				kind_e[wr_q] <= kind_t'(pointer.kind);
				px_e[wr_q]   <= pointer.point_x;
				py_e[wr_q]   <= pointer.point_y;
				wr_q         <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	assign cfg_regs = cfg_q;
	assign q_valid  = cnt_q != 2'd0;
	assign q_kind   = kind_e[rd_q];
	assign q_px     = px_e[rd_q];
	assign q_py     = py_e[rd_q];
endmodule

[design/arb_back.sv]
// Back end: sequencer with one shared multiplier, divider and square root
// that maps points to the sphere and updates the rotations. Depends on
// arb_pkg, arb_div, arb_sqrt and arb_result_if.
module arb_back #(
	parameter int FRAC_BITS  = arb_pkg::FRAC_BITS_DEF,
	parameter int POINT_BITS = arb_pkg::POINT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  arb_pkg::cfg_t         cfg_regs,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  arb_pkg::kind_t        q_kind,
	input  logic [POINT_BITS-1:0] q_px,
	input  logic [POINT_BITS-1:0] q_py,
	arb_result_if.source          result
);
	import arb_pkg::*;

	localparam int F   = FRAC_BITS;
	localparam int SW  = F + 2;
	localparam int NVW = POINT_BITS + F + 3;
	localparam int NW  = ((POINT_BITS + 2 > 30) ? POINT_BITS + 2 : 30) + F;
	localparam int PW  = 2 * MUL_W;
	localparam int AW  = PW + 2;
	localparam int XW  = SW + OUT_W;
	localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << (2 * F);
	localparam logic [SQ_W-1:0] EPS_SQ = (SQ_W'(1) << (2 * F)) / SQ_W'(64'd10000000000);
	localparam logic signed [NVW-1:0] ONE_V = NVW'(1 << F);
	localparam logic signed [SW-1:0]  ONE_S = SW'(1 << F);
	localparam logic signed [XW-1:0]  OMAX  = XW'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [XW-1:0]  OMIN  = -XW'(1 << (OUT_W - 1));

	typedef enum logic [3:0] {
		S_IDLE, S_DIVX, S_DIVY, S_CHK, S_MAC, S_ZSQ,
		S_NINIT, S_NSHIFT, S_NSQ, S_NDIV, S_NEND, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		J_SQ, J_C0, J_C1, J_C2, J_D, J_CSQ, J_Q0, J_Q1, J_Q2, J_Q3, J_SS
	} job_t;

	state_t                  st_q;
	job_t                    job_q;
	logic [1:0]              idx_q;
	logic                    ph_q;
	kind_t                   kind_q;
	logic [POINT_BITS-1:0]   px_q;
	logic [POINT_BITS-1:0]   py_q;
	logic                    n4_q;
	logic                    ok_q;
	logic                    chg_q;
	logic signed [AW-1:0]    acc_q;
	logic signed [PW-1:0]    prod_q;
	logic signed [NVW-1:0]   nv_q [4];
	logic [NVW-1:0]          mg_q [4];
	logic                    sgn_q [4];
	logic [ROOT_W-1:0]       len_q;
	logic signed [SW-1:0]    c_q [3];
	logic signed [SW-1:0]    d_q;
	logic signed [SW-1:0]    srot_q [4];
	logic signed [SW-1:0]    svec_q [3];
	logic signed [SW-1:0]    lrot_q [4];
	logic signed [SW-1:0]    orot_q [4];
	logic signed [SW-1:0]    cur_rot [4];
	logic                    ov_q;
	logic signed [OUT_W-1:0] orw_q, orx_q, ory_q, orz_q;
	logic                    och_q;

	logic [CFG_DATA_W-1:0]   w_eff, h_eff, dw, dh;
	logic                    div_start, div_busy, div_done;
	logic [NW-1:0]           div_num, div_quo;
	logic [ROOT_W-1:0]       div_den;
	logic                    sq_start, sq_busy, sq_done;
	logic [SQ_W-1:0]         sq_in;
	logic [ROOT_W-1:0]       sq_root;
	logic signed [MUL_W-1:0] a_op, b_op, qa;
	logic                    neg, rnd, last;
	logic [1:0]              ridx;
	logic signed [AW-1:0]    term, acc_nx;
	logic                    outside, too_big, ld_out;
	logic [1:0]              n_last;

	function automatic logic signed [AW-1:0] rs(input logic signed [AW-1:0] v);
		logic [AW-1:0] m;
		logic [AW-1:0] r;
		m = v[AW-1] ? AW'(-v) : AW'(v);
		r = (m + (AW'(1) << (F - 1))) >> F;
		rs = v[AW-1] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [OUT_W-1:0] sat(input logic signed [SW-1:0] v);
		logic signed [XW-1:0] x;
		x = XW'(v);
		if (x > OMAX) x = OMAX;
		if (x < OMIN) x = OMIN;
		sat = OUT_W'(x);
	endfunction

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cur_rot[i] = (cfg_regs.mode == MODE_ORBIT) ? orot_q[i] : lrot_q[i];
		end
	end

	// Shared divider and square root operand selection
	always_comb begin
		w_eff   = (cfg_regs.width < CFG_DATA_W'(2)) ? CFG_DATA_W'(2) : cfg_regs.width;
		h_eff   = (cfg_regs.height < CFG_DATA_W'(2)) ? CFG_DATA_W'(2) : cfg_regs.height;
		dw      = w_eff - 1'b1;
		dh      = h_eff - 1'b1;
		div_num = '0;
		div_den = ROOT_W'(1);
		sq_in   = acc_q[SQ_W-1:0];
		unique case (st_q)
			S_DIVX: begin
				div_num = (NW'(px_q) << (F + 1)) + NW'(dw >> 1);
				div_den = ROOT_W'(dw);
			end
			S_DIVY: begin
				div_num = (NW'(py_q) << (F + 1)) + NW'(dh >> 1);
				div_den = ROOT_W'(dh);
			end
			S_NDIV: begin
				div_num = NW'(mg_q[idx_q]) << F;
				div_den = len_q;
			end
			S_ZSQ: begin
				sq_in = ONE_SQ - acc_q[SQ_W-1:0];
			end
			default: begin
			end
		endcase
		div_start = !ph_q && (st_q == S_DIVX || st_q == S_DIVY || st_q == S_NDIV);
		sq_start  = !ph_q && (st_q == S_ZSQ || st_q == S_NSQ);
	end

	// Multiply-accumulate step table
	always_comb begin
		a_op = '0;
		b_op = '0;
		neg  = 1'b0;
		rnd  = 1'b0;
		last = 1'b0;
		ridx = idx_q;
		n_last = n4_q ? 2'd3 : 2'd1;
		unique case (idx_q)
			2'd0: qa = MUL_W'(d_q);
			2'd1: qa = MUL_W'(c_q[0]);
			2'd2: qa = MUL_W'(c_q[1]);
			default: qa = MUL_W'(c_q[2]);
		endcase
		unique case (job_q)
			J_SQ: begin
				a_op = idx_q[0] ? MUL_W'(nv_q[1]) : MUL_W'(nv_q[0]);
				b_op = a_op;
				last = idx_q[0];
			end
			J_C0: begin
				a_op = idx_q[0] ? MUL_W'(svec_q[2]) : MUL_W'(svec_q[1]);
				b_op = idx_q[0] ? MUL_W'(nv_q[1]) : MUL_W'(nv_q[2]);
				neg  = idx_q[0];
				last = idx_q[0];
			end
			J_C1: begin
				a_op = idx_q[0] ? MUL_W'(svec_q[0]) : MUL_W'(svec_q[2]);
				b_op = idx_q[0] ? MUL_W'(nv_q[2]) : MUL_W'(nv_q[0]);
				neg  = idx_q[0];
				last = idx_q[0];
			end
			J_C2: begin
				a_op = idx_q[0] ? MUL_W'(svec_q[1]) : MUL_W'(svec_q[0]);
				b_op = idx_q[0] ? MUL_W'(nv_q[0]) : MUL_W'(nv_q[1]);
				neg  = idx_q[0];
				last = idx_q[0];
			end
			J_D: begin
				unique case (idx_q)
					2'd0: begin
						a_op = MUL_W'(svec_q[0]);
						b_op = MUL_W'(nv_q[0]);
					end
					2'd1: begin
						a_op = MUL_W'(svec_q[1]);
						b_op = MUL_W'(nv_q[1]);
					end
					default: begin
						a_op = MUL_W'(svec_q[2]);
						b_op = MUL_W'(nv_q[2]);
					end
				endcase
				last = idx_q == 2'd2;
			end
			J_CSQ: begin
				unique case (idx_q)
					2'd0: a_op = MUL_W'(c_q[0]);
					2'd1: a_op = MUL_W'(c_q[1]);
					default: a_op = MUL_W'(c_q[2]);
				endcase
				b_op = a_op;
				last = idx_q == 2'd2;
			end
			J_Q0: begin
				ridx = idx_q;
				neg  = idx_q != 2'd0;
			end
			J_Q1: begin
				ridx = idx_q ^ 2'd1;
				neg  = idx_q == 2'd3;
			end
			J_Q2: begin
				ridx = idx_q ^ 2'd2;
				neg  = idx_q == 2'd1;
			end
			J_Q3: begin
				ridx = idx_q ^ 2'd3;
				neg  = idx_q == 2'd2;
			end
			J_SS: begin
				a_op = MUL_W'(mg_q[idx_q]);
				b_op = a_op;
				last = idx_q == n_last;
			end
			default: begin
			end
		endcase
		if (job_q == J_Q0 || job_q == J_Q1 || job_q == J_Q2 || job_q == J_Q3) begin
			a_op = qa;
			b_op = MUL_W'(srot_q[ridx]);
			rnd  = 1'b1;
			last = idx_q == 2'd3;
		end
		term    = rnd ? rs(AW'(prod_q)) : AW'(prod_q);
		acc_nx  = ((idx_q == 2'd0) ? AW'(0) : acc_q) + (neg ? -term : term);
		outside = nv_q[0] > ONE_V || nv_q[0] < -ONE_V || nv_q[1] > ONE_V || nv_q[1] < -ONE_V;
		too_big = 1'b0;
		for (int i = 0; i < 4; i++) begin
			too_big = too_big || ((64'(mg_q[i]) >> 30) != 64'd0);
		end
		ld_out  = (st_q == S_DONE) && (!ov_q || result.ready);
	end

	assign q_pop = (st_q == S_IDLE) && q_valid;

	arb_div #(.NW(NW), .DW(ROOT_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	arb_sqrt #(.W(SQ_W)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.din    (sq_in),
		.busy   (sq_busy),
		.done   (sq_done),
		.root   (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			job_q <= J_SQ;
			idx_q <= '0;
			ph_q  <= 1'b0;
			n4_q  <= 1'b0;
			ok_q  <= 1'b0;
			chg_q <= 1'b0;
			ov_q  <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				srot_q[i] <= (i == 0) ? ONE_S : '0;
				lrot_q[i] <= (i == 0) ? ONE_S : '0;
				orot_q[i] <= (i == 0) ? ONE_S : '0;
			end
			for (int i = 0; i < 3; i++) begin
				svec_q[i] <= '0;
			end
		end else begin
			// a new result loaded in the same cycle keeps the register full
			if (ov_q && result.ready && !ld_out) begin
				ov_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						kind_q <= q_kind;
						px_q   <= q_px;
						py_q   <= q_py;
						chg_q  <= 1'b0;
						ph_q   <= 1'b0;
						if (q_kind == KIND_CLICK) begin
							for (int i = 0; i < 4; i++) srot_q[i] <= cur_rot[i];
						end
						st_q <= S_DIVX;
					end
				end
				S_DIVX: begin
					if (!ph_q) ph_q <= 1'b1;
					else if (div_done) begin
						nv_q[0] <= NVW'(div_quo) - ONE_V;
						ph_q    <= 1'b0;
						st_q    <= S_DIVY;
					end
				end
				S_DIVY: begin
					if (!ph_q) ph_q <= 1'b1;
					else if (div_done) begin
						nv_q[1] <= ONE_V - NVW'(div_quo);
						ph_q    <= 1'b0;
						st_q    <= S_CHK;
					end
				end
				S_CHK: begin
					n4_q  <= 1'b0;
					idx_q <= '0;
					job_q <= J_SQ;
					st_q  <= outside ? S_NINIT : S_MAC;
				end
				S_MAC: begin
					if (!ph_q) begin
						prod_q <= PW'(a_op * b_op);
						ph_q   <= 1'b1;
					end else begin
						acc_q <= acc_nx;
						ph_q  <= 1'b0;
						if (!last) begin
							idx_q <= idx_q + 1'b1;
						end else begin
							idx_q <= '0;
							unique case (job_q)
								J_SQ: st_q <= (acc_nx > AW'(ONE_SQ)) ? S_NINIT : S_ZSQ;
								J_C0: begin
									c_q[0] <= SW'(rs(acc_nx));
									job_q  <= J_C1;
								end
								J_C1: begin
									c_q[1] <= SW'(rs(acc_nx));
									job_q  <= J_C2;
								end
								J_C2: begin
									c_q[2] <= SW'(rs(acc_nx));
									job_q  <= J_D;
								end
								J_D: begin
									d_q   <= SW'(rs(acc_nx));
									job_q <= J_CSQ;
								end
								J_CSQ: begin
									if (acc_nx > AW'(EPS_SQ)) job_q <= J_Q0;
									else st_q <= S_DONE;
								end
								J_Q0: begin
									nv_q[0] <= NVW'(acc_nx);
									job_q   <= J_Q1;
								end
								J_Q1: begin
									nv_q[1] <= NVW'(acc_nx);
									job_q   <= J_Q2;
								end
								J_Q2: begin
									nv_q[2] <= NVW'(acc_nx);
									job_q   <= J_Q3;
								end
								J_Q3: begin
									nv_q[3] <= NVW'(acc_nx);
									n4_q    <= 1'b1;
									st_q    <= S_NINIT;
								end
								J_SS: st_q <= S_NSQ;
								default: st_q <= S_IDLE;
							endcase
						end
					end
				end
				S_ZSQ: begin
					if (!ph_q) ph_q <= 1'b1;
					else if (sq_done) begin
						nv_q[2] <= NVW'(sq_root);
						ph_q    <= 1'b0;
						st_q    <= S_NEND;
					end
				end
				S_NINIT: begin
					for (int i = 0; i < 4; i++) begin
						sgn_q[i] <= nv_q[i][NVW-1];
						if (i < 2 || n4_q) begin
							mg_q[i] <= nv_q[i][NVW-1] ? NVW'(-nv_q[i]) : NVW'(nv_q[i]);
						end else begin
							mg_q[i] <= '0;
						end
					end
					if (!n4_q) nv_q[2] <= '0;
					ok_q <= 1'b0;
					st_q <= S_NSHIFT;
				end
				S_NSHIFT: begin
					if (too_big) begin
						for (int i = 0; i < 4; i++) mg_q[i] <= mg_q[i] >> 1;
					end else begin
						job_q <= J_SS;
						idx_q <= '0;
						ph_q  <= 1'b0;
						st_q  <= S_MAC;
					end
				end
				S_NSQ: begin
					if (!ph_q) ph_q <= 1'b1;
					else if (sq_done) begin
						len_q <= sq_root;
						ph_q  <= 1'b0;
						idx_q <= '0;
						st_q  <= (sq_root == '0) ? S_NEND : S_NDIV;
					end
				end
				S_NDIV: begin
					if (!ph_q) ph_q <= 1'b1;
					else if (div_done) begin
						nv_q[idx_q] <= sgn_q[idx_q] ? -NVW'(div_quo) : NVW'(div_quo);
						ph_q        <= 1'b0;
						if (idx_q == n_last) begin
							ok_q <= 1'b1;
							st_q <= S_NEND;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_NEND: begin
					idx_q <= '0;
					ph_q  <= 1'b0;
					if (n4_q) begin
						if (ok_q) begin
							for (int i = 0; i < 4; i++) begin
								if (cfg_regs.mode == MODE_ORBIT) orot_q[i] <= SW'(nv_q[i]);
								else lrot_q[i] <= SW'(nv_q[i]);
							end
							chg_q <= 1'b1;
						end
						st_q <= S_DONE;
					end else if (kind_q == KIND_CLICK) begin
						for (int i = 0; i < 3; i++) svec_q[i] <= SW'(nv_q[i]);
						st_q <= S_DONE;
					end else begin
						job_q <= J_C0;
						st_q  <= S_MAC;
					end
				end
				S_DONE: begin
					if (ld_out) begin
						orw_q <= sat(cur_rot[0]);
						orx_q <= sat(cur_rot[1]);
						ory_q <= sat(cur_rot[2]);
						orz_q <= sat(cur_rot[3]);
						och_q <= chg_q;
						ov_q  <= 1'b1;
						st_q  <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid   = ov_q;
	assign result.rot_w   = orw_q;
	assign result.rot_x   = orx_q;
	assign result.rot_y   = ory_q;
	assign result.rot_z   = orz_q;
	assign result.changed = och_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (st_q == S_IDLE && q_valid))
		else $error("queue popped outside idle");
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |=> (ov_q && st_q == S_IDLE))
		else $error("result load did not complete");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");
	a_sqrt_free: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |-> !sq_busy)
		else $error("square root restarted while busy");
endmodule

[design/arcball_rotation_unit.sv]
// Arcball rotation unit: top level joining the front queue and the back
// sequencer. Depends on arb_pkg, arb_if, arb_front and arb_back.
//
// Usage: pointer carries click (kind 0) or drag (kind 1) transactions with a
// pixel point; each one yields exactly one transaction on result, holding the
// selected mode's rotation quaternion (Q1.16 by default) and a changed flag.
// cfg writes viewport_width (0), viewport_height (1) and movement_mode (2);
// it is always ready and must be used only while the unit is idle.
// One item is worked at a time by a sequencer around a shared 32x32
// multiplier, a one-bit-per-cycle divider and a two-bit-per-cycle square
// root. A drag whose cross product vanishes leaves the rotations unchanged.
// Up to two items queue at the input while one is worked, and a finished
// result waits in an output register; when the receiver stalls the
// sequencer holds its next result until that register frees.
// Reset clears the queue, sets the viewport to 640 by 480, look-at mode,
// all rotations to identity and the start vector to zero.
module arcball_rotation_unit #(
	parameter int FRAC_BITS  = arb_pkg::FRAC_BITS_DEF,
	parameter int POINT_BITS = arb_pkg::POINT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	arb_point_if.sink    pointer,
	arb_cfg_if.sink      cfg,
	arb_result_if.source result
);
	import arb_pkg::*;

	cfg_t                  cfg_regs;
	logic                  q_valid;
	logic                  q_pop;
	kind_t                 q_kind;
	logic [POINT_BITS-1:0] q_px;
	logic [POINT_BITS-1:0] q_py;

	arb_front #(.POINT_BITS(POINT_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pointer  (pointer),
		.cfg      (cfg),
		.cfg_regs (cfg_regs),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_kind   (q_kind),
		.q_px     (q_px),
		.q_py     (q_py)
	);

	arb_back #(.FRAC_BITS(FRAC_BITS), .POINT_BITS(POINT_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_regs),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_kind   (q_kind),
		.q_px     (q_px),
		.q_py     (q_py),
		.result   (result)
	);
endmodule

[tb/arcball_rotation_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of arcball_rotation_unit: random click/drag traffic with a
// fixed-point arcball predictor. Depends on arb_pkg, arb_if and the unit's RTL.
module arcball_rotation_unit_tb;
	import arb_pkg::*;

	localparam int  FB        = FRAC_BITS_DEF;
	localparam int  PB        = POINT_BITS_DEF;
	localparam longint ONE_Q  = longint'(1) << FB;
	localparam int  DOG_LIMIT = 20000;
	localparam int  LONG_HOLD = 1500;

	typedef struct {
		kind_t          kind;
		logic [PB-1:0]  px;
		logic [PB-1:0]  py;
	} pointer_item_t;

	typedef struct {
		logic signed [OUT_W-1:0] w, x, y, z;
		logic                    changed;
	} rotation_t;

	logic clk;
	logic arst_n;

	arb_point_if #(.POINT_BITS(PB)) pointer ();
	arb_cfg_if    cfg ();
	arb_result_if result ();

	arcball_rotation_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.pointer(pointer),
		.cfg(cfg),
		.result(result)
	);

	// predictor state
	longint  vp_width, vp_height;
	mode_t   vp_mode;
	longint  lookat_q[4], orbit_q[4], anchor_q[4];
	longint  anchor_v[3];

	pointer_item_t pending_points[$];
	rotation_t     expected_rotations[$];
	int  errors;
	bit  idle_on;
	int  hold_requests;
	int  hold_served;
	int  dog_count;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint fix_round(input longint v);
		longint unsigned half, m;
		half = 64'd1 << (FB - 1);
		if (v < 0) begin
			m = longint'(-v);
			return -longint'((m + half) >> FB);
		end
		m = v;
		return longint'((m + half) >> FB);
	endfunction

	function automatic bit unit_length(inout longint v[4], input int n);
		longint unsigned mag[4], m, sum, len, q;
		int s;
		m = 0;
		sum = 0;
		s = 0;
		for (int i = 0; i < n; i++) begin
			mag[i] = v[i] < 0 ? longint'(-v[i]) : v[i];
			if (mag[i] > m) m = mag[i];
		end
		while ((m >> s) >= (64'd1 << 30)) s++;
		for (int i = 0; i < n; i++) begin
			mag[i] >>= s;
			sum += mag[i] * mag[i];
		end
		len = int_sqrt(sum);
		if (len == 0) return 1'b0;
		for (int i = 0; i < n; i++) begin
			q = (mag[i] * longint'(ONE_Q)) / len;
			v[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	function automatic void sphere_point(input logic [PB-1:0] px, input logic [PB-1:0] py,
			output longint v[3]);
		longint unsigned dw, dh, one2, sq;
		longint sx, sy, t[4];
		bit ok, outside;
		dw = (vp_width < 2 ? 2 : vp_width) - 1;
		dh = (vp_height < 2 ? 2 : vp_height) - 1;
		sx = longint'((longint'(px) * 2 * ONE_Q + dw / 2) / dw) - ONE_Q;
		sy = ONE_Q - longint'((longint'(py) * 2 * ONE_Q + dh / 2) / dh);
		outside = sx > ONE_Q || sx < -ONE_Q || sy > ONE_Q || sy < -ONE_Q;
		one2 = ONE_Q * ONE_Q;
		if (!outside) begin
			sq = longint'(sx * sx) + longint'(sy * sy);
			if (sq > one2) begin
				outside = 1'b1;
			end else begin
				v[0] = sx;
				v[1] = sy;
				v[2] = longint'(int_sqrt(one2 - sq));
			end
		end
		if (outside) begin
			t[0] = sx;
			t[1] = sy;
			t[2] = 0;
			t[3] = 0;
			ok = unit_length(t, 2);
			v[0] = t[0];
			v[1] = t[1];
			v[2] = 0;
		end
	endfunction

	function automatic logic signed [OUT_W-1:0] clamp_out(input longint v);
		if (v > 131071) v = 131071;
		if (v < -131072) v = -131072;
		return v[OUT_W-1:0];
	endfunction

	function automatic rotation_t arcball_step(input pointer_item_t it);
		rotation_t res;
		longint e[3], c[3], d, q[4], rot[4];
		longint unsigned csq;
		res.changed = 1'b0;
		rot = (vp_mode == MODE_ORBIT) ? orbit_q : lookat_q;
		if (it.kind == KIND_CLICK) begin
			anchor_q = rot;
			sphere_point(it.px, it.py, anchor_v);
		end else begin
			sphere_point(it.px, it.py, e);
			c[0] = fix_round(anchor_v[1] * e[2] - anchor_v[2] * e[1]);
			c[1] = fix_round(anchor_v[2] * e[0] - anchor_v[0] * e[2]);
			c[2] = fix_round(anchor_v[0] * e[1] - anchor_v[1] * e[0]);
			d = fix_round(anchor_v[0] * e[0] + anchor_v[1] * e[1] + anchor_v[2] * e[2]);
			csq = longint'(c[0] * c[0]) + longint'(c[1] * c[1]) + longint'(c[2] * c[2]);
			// epsilon squared truncates to zero at 16 fraction bits
			if (csq > ((64'd1 << (2 * FB)) / 64'd10000000000)) begin
				q[0] = fix_round(d * anchor_q[0]) - fix_round(c[0] * anchor_q[1])
					- fix_round(c[1] * anchor_q[2]) - fix_round(c[2] * anchor_q[3]);
				q[1] = fix_round(d * anchor_q[1]) + fix_round(c[0] * anchor_q[0])
					+ fix_round(c[1] * anchor_q[3]) - fix_round(c[2] * anchor_q[2]);
				q[2] = fix_round(d * anchor_q[2]) - fix_round(c[0] * anchor_q[3])
					+ fix_round(c[1] * anchor_q[0]) + fix_round(c[2] * anchor_q[1]);
				q[3] = fix_round(d * anchor_q[3]) + fix_round(c[0] * anchor_q[2])
					- fix_round(c[1] * anchor_q[1]) + fix_round(c[2] * anchor_q[0]);
				if (unit_length(q, 4)) begin
					rot = q;
					res.changed = 1'b1;
					if (vp_mode == MODE_ORBIT) orbit_q = q;
					else lookat_q = q;
				end
			end
		end
		res.w = clamp_out(rot[0]);
		res.x = clamp_out(rot[1]);
		res.y = clamp_out(rot[2]);
		res.z = clamp_out(rot[3]);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
	endtask

	// pointer driver
	int src_gap;
	always @(posedge clk or negedge arst_n) begin
		bit     sent;
		int     idx;
		if (!arst_n) begin
			pointer.valid   <= 1'b0;
			pointer.kind    <= KIND_CLICK;
			pointer.point_x <= '0;
			pointer.point_y <= '0;
			src_gap = 0;
		end else begin
			sent = pointer.valid && pointer.ready;
			idx = 0;
			if (sent) begin
				expected_rotations.push_back(arcball_step(pending_points[0]));
				idx = 1;
			end
			if (pointer.valid && !sent) begin
				// hold the offered transaction
			end else begin
				if (src_gap == 0 && idle_on && $urandom_range(0, 7) == 0)
					src_gap = $urandom_range(1, 12);
				if (src_gap > 0) begin
					src_gap--;
					pointer.valid <= 1'b0;
				end else if (pending_points.size() > idx) begin
					pointer.valid   <= 1'b1;
					pointer.kind    <= pending_points[idx].kind;
					pointer.point_x <= pending_points[idx].px;
					pointer.point_y <= pending_points[idx].py;
				end else begin
					pointer.valid <= 1'b0;
				end
			end
			if (sent) void'(pending_points.pop_front());
		end
	end

	// result receiver and checker
	int sink_gap;
	int sink_hold;
	always @(posedge clk or negedge arst_n) begin
		rotation_t want;
		if (!arst_n) begin
			result.ready <= 1'b0;
			sink_gap = 0;
			sink_hold = 0;
			hold_served = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_rotations.size() == 0) begin
					errors++;
					$display("%0t result transaction with nothing expected", $realtime);
				end else begin
					want = expected_rotations.pop_front();
					if (result.rot_w !== want.w) report_mismatch("rot_w", result.rot_w, want.w);
					if (result.rot_x !== want.x) report_mismatch("rot_x", result.rot_x, want.x);
					if (result.rot_y !== want.y) report_mismatch("rot_y", result.rot_y, want.y);
					if (result.rot_z !== want.z) report_mismatch("rot_z", result.rot_z, want.z);
					if (result.changed !== want.changed)
						report_mismatch("changed", result.changed, want.changed);
				end
			end
			if (sink_hold == 0 && hold_served != hold_requests) begin
				hold_served++;
				sink_hold = LONG_HOLD;
			end
			if (sink_gap == 0 && sink_hold == 0 && idle_on && $urandom_range(0, 7) == 0)
				sink_gap = $urandom_range(1, 12);
			if (sink_hold > 0) begin
				sink_hold--;
				result.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if ((pointer.valid && pointer.ready) || (result.valid && result.ready)
				|| (cfg.valid && cfg.ready) || !arst_n)
			dog_count = 0;
		else
			dog_count++;
		if (dog_count >= DOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_WIDTH:  vp_width = value;
			REG_HEIGHT: vp_height = value;
			default:    vp_mode = mode_t'(value[0]);
		endcase
	endtask

	task automatic set_viewport(input int w, input int h, input mode_t m);
		cfg_write(REG_WIDTH, w);
		cfg_write(REG_HEIGHT, h);
		cfg_write(REG_MODE, m);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain;
		while (pending_points.size() != 0 || expected_rotations.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_point(input kind_t k, input int x, input int y);
		pointer_item_t it;
		it.kind = k;
		it.px = x;
		it.py = y;
		pending_points.push_back(it);
	endtask

	function automatic int pick_coord(input longint span);
		longint lim;
		lim = span < 2 ? 2 : span;
		if (lim > 8192) lim = 8192;
		if ($urandom_range(0, 9) < 8) return $urandom_range(0, int'(lim) - 1);
		return $urandom_range(0, 8191);
	endfunction

	// click followed by a few drags, with some noise and broken sequences
	task automatic gestures(input int n);
		int cnt, drags;
		cnt = 0;
		while (cnt < n) begin
			if ($urandom_range(0, 9) == 0) begin
				add_point(kind_t'($urandom_range(0, 1)), $urandom_range(0, 8191),
					$urandom_range(0, 8191));
				cnt++;
			end else begin
				add_point(KIND_CLICK, pick_coord(vp_width), pick_coord(vp_height));
				drags = $urandom_range(1, 6);
				for (int i = 0; i < drags; i++)
					add_point(KIND_DRAG, pick_coord(vp_width), pick_coord(vp_height));
				cnt += drags + 1;
			end
		end
	endtask

	initial begin
		errors = 0;
		idle_on = 1'b1;
		hold_requests = 0;
		cfg.valid = 1'b0;
		cfg.index = REG_WIDTH;
		cfg.data = '0;
		vp_width = 640;
		vp_height = 480;
		vp_mode = MODE_LOOKAT;
		for (int i = 0; i < 4; i++) begin
			lookat_q[i] = i == 0 ? ONE_Q : 0;
			orbit_q[i] = lookat_q[i];
			anchor_q[i] = lookat_q[i];
		end
		anchor_v = '{0, 0, 0};
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// drag before any click, then extremes at reset geometry
		add_point(KIND_DRAG, 100, 100);
		add_point(KIND_CLICK, 320, 240);
		add_point(KIND_DRAG, 320, 240);
		add_point(KIND_DRAG, 0, 0);
		add_point(KIND_DRAG, 639, 479);
		add_point(KIND_DRAG, 8191, 8191);
		add_point(KIND_CLICK, 0, 8191);
		add_point(KIND_DRAG, 8191, 0);
		add_point(KIND_CLICK, 600, 30);
		add_point(KIND_DRAG, 40, 450);
		add_point(KIND_CLICK, 5461, 2730);
		add_point(KIND_DRAG, 2730, 5461);
		drain();

		// orbit mode on a tiny viewport: the first drag uses the earlier click's look-at rotation
		set_viewport(2, 2, MODE_ORBIT);
		add_point(KIND_DRAG, 1, 0);
		add_point(KIND_CLICK, 0, 0);
		add_point(KIND_DRAG, 1, 1);
		add_point(KIND_CLICK, 1, 0);
		drain();
		set_viewport(1, 0, MODE_LOOKAT);
		add_point(KIND_DRAG, 0, 1);
		add_point(KIND_CLICK, 1, 1);
		add_point(KIND_DRAG, 0, 0);
		drain();
		set_viewport(8192, 8192, MODE_ORBIT);
		add_point(KIND_CLICK, 0, 4095);
		add_point(KIND_DRAG, 4096, 0);
		add_point(KIND_DRAG, 8191, 4095);
		drain();
		set_viewport(16383, 3, MODE_LOOKAT);
		add_point(KIND_CLICK, 8191, 1);
		add_point(KIND_DRAG, 100, 2);
		drain();

		// random phases; the receiver holds off during one of them
		for (int ph = 0; ph < 8; ph++) begin
			set_viewport($urandom_range(2, 8192), $urandom_range(2, 8192),
				mode_t'($urandom_range(0, 1)));
			if (ph == 7) idle_on = 1'b0;
			gestures(55);
			if ($urandom_range(0, 1) == 1) add_point(KIND_CLICK, pick_coord(vp_width),
				pick_coord(vp_height));
			if (ph == 2) hold_requests++;
			drain();
		end

		repeat (700) @(posedge clk);
		if (expected_rotations.size() != 0) errors++;
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
